/* rtl/lpr_pkg.sv */
// shared types and constants for the lru page replacement block
package lpr_pkg;

   localparam int FRAME_SLOTS_DEFAULT = 8;
   localparam int PAGE_BITS_DEFAULT   = 16;
   localparam int PAGE_PORT_W         = 16;
   localparam int FRAME_IDX_W         = 3;
   localparam int COUNT_W             = 32;
   localparam int CSR_W               = 4;
   localparam logic [CSR_W-1:0] FRAMES_IN_USE_RESET = 4'd8;

   typedef enum logic {
      LPR_IDLE,
      LPR_EXEC
   } lpr_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } lpr_cmd_type;

endpackage

/* rtl/lpr_ctrl.sv */
// controller state machine: accepts a transaction and sequences the datapath
module lpr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   output lpr_pkg::lpr_cmd_type cmd
);
   import lpr_pkg::*;

   lpr_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LPR_IDLE: begin
            if (start) state_in = LPR_EXEC;
         end
         LPR_EXEC: begin
            state_in = LPR_IDLE;
         end
         default: begin
            state_in = LPR_IDLE;
         end
      endcase
   end

   always_comb begin
      busy         = 1'b0;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      case (state_ff)
         LPR_IDLE: begin
            cmd.capture = start;
         end
         LPR_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.execute;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LPR_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      !reset && state_ff == LPR_EXEC |=> state_ff == LPR_IDLE)
      else $error("exec state held more than one cycle");
   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      !reset && cmd.execute |=> rsp_valid_ff && !busy)
      else $error("result strobe missing after exec");
`endif

endmodule

/* rtl/lpr_datapath.sv */
// frame table, recency ranks, fault counter and result registers
module lpr_datapath #(
   parameter int FRAME_SLOTS = lpr_pkg::FRAME_SLOTS_DEFAULT,
   parameter int PAGE_BITS   = lpr_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lpr_pkg::lpr_cmd_type            cmd,
   input  logic                            csr_wr_en,
   input  logic [lpr_pkg::CSR_W-1:0]       csr_wr_data,
   input  logic [lpr_pkg::PAGE_PORT_W-1:0] req_page_number,
   input  logic                            req_last_reference,
   output logic                            rsp_hit,
   output logic [lpr_pkg::FRAME_IDX_W-1:0] rsp_frame_index,
   output logic                            rsp_evicted_valid,
   output logic [lpr_pkg::PAGE_PORT_W-1:0] rsp_evicted_page,
   output logic [lpr_pkg::COUNT_W-1:0]     rsp_fault_count
);
   import lpr_pkg::*;

   localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] RANK_MAX = SLOT_W'(FRAME_SLOTS - 1);

   logic [CSR_W-1:0]     frames_ff, frames_in;
   logic [PAGE_BITS-1:0] req_page_ff;
   logic                 req_last_ff;
   logic [PAGE_BITS-1:0] page_ff [FRAME_SLOTS];
   logic [FRAME_SLOTS-1:0] valid_ff, valid_in;
   logic [SLOT_W-1:0]    rank_ff [FRAME_SLOTS];
   logic [SLOT_W-1:0]    rank_in [FRAME_SLOTS];
   logic [COUNT_W-1:0]   faults_ff, faults_in, faults_next;

   logic                 rsp_hit_ff;
   logic [FRAME_IDX_W-1:0] rsp_frame_ff;
   logic                 rsp_ev_valid_ff;
   logic [PAGE_PORT_W-1:0] rsp_ev_page_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic [FRAME_SLOTS-1:0] active, match, empty;
   logic                 hit, empty_any, age_all;
   logic [SLOT_W-1:0]    hit_slot, empty_slot, oldest_slot, oldest_rank, slot;

   assign frames_in = csr_wr_en ? csr_wr_data : frames_ff;

   // slot 0 always takes part; slots past the configured count sit out
   always_comb begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         active[i] = (i == 0) || (32'(i) < 32'(frames_ff));
         match[i]  = active[i] && valid_ff[i] && (page_ff[i] == req_page_ff);
         empty[i]  = active[i] && !valid_ff[i];
      end
   end

   always_comb begin
      hit_slot   = '0;
      empty_slot = '0;
      for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
         if (match[i]) hit_slot = SLOT_W'(i);
         if (empty[i]) empty_slot = SLOT_W'(i);
      end
   end

   // lowest-numbered frame with the largest rank
   always_comb begin
      oldest_slot = '0;
      oldest_rank = '0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         if (active[i] && rank_ff[i] > oldest_rank) begin
            oldest_rank = rank_ff[i];
            oldest_slot = SLOT_W'(i);
         end
      end
   end

   assign hit       = |match;
   assign empty_any = |empty;
   assign age_all   = !hit && empty_any;
   assign slot      = hit ? hit_slot : (empty_any ? empty_slot : oldest_slot);

   assign faults_next = (!hit && faults_ff != '1) ? faults_ff + COUNT_W'(1) : faults_ff;

   always_comb begin
      valid_in  = valid_ff;
      faults_in = faults_ff;
      for (int i = 0; i < FRAME_SLOTS; i++) rank_in[i] = rank_ff[i];
      if (cmd.execute) begin
         for (int i = 0; i < FRAME_SLOTS; i++) begin
            if (active[i] && SLOT_W'(i) != slot && valid_ff[i] &&
                (age_all || rank_ff[i] < rank_ff[slot]) && rank_ff[i] != RANK_MAX) begin
               rank_in[i] = rank_ff[i] + SLOT_W'(1);
            end
         end
         rank_in[slot] = '0;
         if (!hit) valid_in[slot] = 1'b1;
         faults_in = faults_next;
         if (req_last_ff) begin
            valid_in  = '0;
            faults_in = '0;
            for (int i = 0; i < FRAME_SLOTS; i++) rank_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_IN_USE_RESET;
         valid_ff  <= '0;
         faults_ff <= '0;
         for (int i = 0; i < FRAME_SLOTS; i++) rank_ff[i] <= '0;
      end else begin
         frames_ff <= frames_in;
         valid_ff  <= valid_in;
         faults_ff <= faults_in;
         for (int i = 0; i < FRAME_SLOTS; i++) rank_ff[i] <= rank_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_page_ff <= PAGE_BITS'(req_page_number);
         req_last_ff <= req_last_reference;
      end
      if (cmd.execute) begin
         if (!hit) page_ff[slot] <= req_page_ff;
         rsp_hit_ff      <= hit;
         rsp_frame_ff    <= FRAME_IDX_W'(slot);
         rsp_ev_valid_ff <= !hit && !empty_any;
         rsp_ev_page_ff  <= (!hit && !empty_any) ? PAGE_PORT_W'(page_ff[slot]) : '0;
         rsp_count_ff    <= faults_next;
      end
   end

   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_count   = rsp_count_ff;

`ifndef SYNTH
   a_touched_is_newest: assert property (@(posedge clock) disable iff (reset)
      !reset && cmd.execute && !req_last_ff |=> rank_ff[$past(slot)] == '0)
      else $error("referenced frame not made most recent");
   a_miss_fills_slot: assert property (@(posedge clock) disable iff (reset)
      !reset && cmd.execute && !hit && !req_last_ff |=> valid_ff[$past(slot)])
      else $error("faulted frame not marked valid");
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset && cmd.execute && !req_last_ff |=> faults_ff >= $past(faults_ff))
      else $error("fault count went down within a reference string");
`endif

endmodule

/* rtl/lru_page_replacement.sv */
// top level of the lru page replacement block
//
// usage:
//   a page reference is taken when start is high and busy is low; the
//   reference is req_page_number plus req_last_reference.
//   one result per reference appears on the rsp_ ports for a single cycle,
//   marked by rsp_valid; the strobe is registered from the execute state,
//   so it rises in the cycle after execute, when the receiver takes the result.
//   busy is high for the one execute cycle after acceptance, so no new
//   reference is taken while one executes; the frame lookup, victim choice
//   and rank update all happen in the execute state of the datapath.
//   a new reference may be taken while the previous result is on the ports.
//   the receiver cannot stall; results are never held.
//   csr_wr_en/csr_wr_data write frames_in_use (reset 8); write only when idle.
//   reset empties all frames, clears ranks and the fault count; a reference
//   marked last does the same after its result is formed, keeping the csr.
module lru_page_replacement #(
   parameter int FRAME_SLOTS = lpr_pkg::FRAME_SLOTS_DEFAULT,
   parameter int PAGE_BITS   = lpr_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [lpr_pkg::PAGE_PORT_W-1:0] req_page_number,
   input  logic                            req_last_reference,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic [lpr_pkg::FRAME_IDX_W-1:0] rsp_frame_index,
   output logic                            rsp_evicted_valid,
   output logic [lpr_pkg::PAGE_PORT_W-1:0] rsp_evicted_page,
   output logic [lpr_pkg::COUNT_W-1:0]     rsp_fault_count,
   input  logic                            csr_wr_en,
   input  logic [lpr_pkg::CSR_W-1:0]       csr_wr_data
);
   import lpr_pkg::*;

   lpr_cmd_type cmd;

   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   lpr_datapath #(
      .FRAME_SLOTS (FRAME_SLOTS),
      .PAGE_BITS   (PAGE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_page_number    (req_page_number),
      .req_last_reference (req_last_reference),
      .rsp_hit            (rsp_hit),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_fault_count    (rsp_fault_count)
   );

endmodule
